// ----- hw/rtl/pbdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbdc_pkg;

  // Number of Pell weights in the table, one cell each.
  localparam int DIGITS = 30;

  localparam int VALUE_W = 32;
  localparam int WEIGHT_W = VALUE_W + 1;
  localparam int DIGIT_W = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 2'd0;
  localparam logic [DIGIT_W-1:0] DIGIT_ONE = 2'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_TWO = 2'd2;

  // A weight that cannot fit into any input value saturates to 2^VALUE_W.
  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {1'b1, {VALUE_W{1'b0}}};

  // Conversion in flight, handed from one cell to the next.
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] rem;
    logic               lead;
  } tok_t;

  // Digit produced by a cell in its cycle.
  typedef struct packed {
    logic               vld;
    logic [DIGIT_W-1:0] digit;
  } emit_t;

  // Pell number p[idx], p[0] = 1, p[1] = 2. Only evaluated on constants.
  function automatic logic [WEIGHT_W-1:0] pell_weight(input int idx);
    logic [63:0] prev;
    logic [63:0] cur;
    logic [63:0] nxt;
    prev = 64'd1;
    cur = 64'd2;
    nxt = 64'd0;
    if (idx == 0) begin
      cur = 64'd1;
    end else begin
      for (int i = 2; i <= idx; i++) begin
        nxt = 64'd2 * cur + prev;
        prev = cur;
        cur = nxt;
      end
    end
    if (cur[63:VALUE_W] != '0) begin
      return WEIGHT_SAT;
    end
    return {1'b0, cur[VALUE_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pbdc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbdc_cell
  import pbdc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [WEIGHT_W-1:0] weight,
  input  wire logic                tail,
  input  wire tok_t                tok_in,
  output tok_t                     tok_out,
  output emit_t                    emit
);

  tok_t tok;

  logic [WEIGHT_W:0] w1;
  logic [WEIGHT_W:0] w2;
  logic [WEIGHT_W:0] rem_ext;
  logic [DIGIT_W-1:0] digit;
  logic [VALUE_W-1:0] rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  assign w1 = {1'b0, weight};
  assign w2 = {weight, 1'b0};
  assign rem_ext = {{(WEIGHT_W + 1 - VALUE_W){1'b0}}, tok.rem};

  always_comb begin
    if (w2 <= rem_ext) begin
      digit = DIGIT_TWO;
      rem_next = tok.rem - w2[VALUE_W-1:0];
    end else if (w1 <= rem_ext) begin
      digit = DIGIT_ONE;
      rem_next = tok.rem - w1[VALUE_W-1:0];
    end else begin
      digit = DIGIT_ZERO;
      rem_next = tok.rem;
    end
  end

  assign tok_out.vld = tok.vld;
  assign tok_out.rem = rem_next;
  assign tok_out.lead = tok.lead & (digit == DIGIT_ZERO);

  // The lowest position always speaks, so a zero input still gives one digit.
  assign emit.vld = tok.vld & ((digit != DIGIT_ZERO) | ~tok.lead | tail);
  assign emit.digit = digit;

endmodule

`default_nettype wire

// ----- hw/rtl/pell_base_digit_converter.sv -----
// Channel   Handshake              Payload         Notes
// request   start, busy            value[31:0]     taken when start && !busy
// result    valid                  digit[1:0],last one strobe per digit, no hold
//
// A conversion walks a chain of DIGITS cells, one per Pell weight, one cell per
// cycle, highest weight first; each cell owns one digit position.
// The chain holds one item at a time; a new request is taken in the cycle
// the previous one sits in the lowest cell. No 32-bit value reaches a weight
// above p[25], so the first digit comes from the p[25] cell at the earliest;
// at most 26 digits come out on consecutive cycles, the final one from the
// lowest cell, marked by last.
// Reset (synchronous) only clears the busy flag, the cell valid bits and the strobe.
// The receiver cannot stall; results leave on their strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module pell_base_digit_converter
  import pbdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    valid,
  output logic [DIGIT_W-1:0]      digit,
  output logic                    last
);

  tok_t  link [DIGITS];
  emit_t emits [DIGITS];

  logic               accept;
  logic               active;
  logic               active_next;
  tok_t               entry;
  logic               valid_next;
  logic [DIGIT_W-1:0] digit_next;
  logic [DIGITS-1:0]  held_vec;
  logic [DIGITS-1:0]  emit_vec;

  assign accept = start & ~busy;
  assign busy = active & ~link[0].vld;

  assign entry.vld = accept;
  assign entry.rem = value;
  assign entry.lead = 1'b1;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    if (i == DIGITS - 1) begin : g_top
      pbdc_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .weight (pell_weight(i)),
        .tail   (1'b0),
        .tok_in (entry),
        .tok_out(link[i]),
        .emit   (emits[i])
      );
    end else begin : g_mid
      pbdc_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .weight (pell_weight(i)),
        .tail   (i == 0),
        .tok_in (link[i+1]),
        .tok_out(link[i]),
        .emit   (emits[i])
      );
    end
    assign held_vec[i] = link[i].vld;
    assign emit_vec[i] = emits[i].vld;
  end

  always_comb begin
    active_next = active;
    if (accept) begin
      active_next = 1'b1;
    end else if (link[0].vld) begin
      active_next = 1'b0;
    end
  end

  // Only one cell holds a conversion, so an AND-OR picks its digit.
  always_comb begin
    valid_next = 1'b0;
    digit_next = DIGIT_ZERO;
    for (int i = 0; i < DIGITS; i++) begin
      valid_next = valid_next | emits[i].vld;
      digit_next = digit_next | (emits[i].digit & {DIGIT_W{emits[i].vld}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      valid <= 1'b0;
    end else begin
      active <= active_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
    last <= emits[0].vld;
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(held_vec))
    else $error("more than one conversion in the cell chain");

  a_one_emit: assert property (@(posedge clk) disable iff (rst) $onehot0(emit_vec))
    else $error("more than one cell produced a digit");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    accept |=> link[DIGITS-1].vld)
    else $error("accepted request did not enter the top cell");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (digit == DIGIT_ZERO || digit == DIGIT_ONE || digit == DIGIT_TWO))
    else $error("digit out of range");

  a_tail_done: assert property (@(posedge clk) disable iff (rst)
    (link[0].vld && !accept) |=> !busy && !active)
    else $error("block stayed busy after the lowest cell finished");

endmodule

`default_nettype wire
